@@ rtl/core/fpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed pattern byte matcher package
// Shared types and constants for the matcher top level and its history cells.
// ----------------------------------------------------------------------------
package fpbm_pkg;

    localparam int LEN_W     = 6;   // pattern length register width
    localparam int PAT_BYTES = 32;  // bytes held by the four pattern registers
    localparam int PAT_IDX_W = 5;   // index into the pattern bytes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int START_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH    = 3'd0,
        CFG_PATTERN_0 = 3'd1,
        CFG_PATTERN_1 = 3'd2,
        CFG_PATTERN_2 = 3'd3,
        CFG_PATTERN_3 = 3'd4
    } t_cfg_index;

    // byte 0 in the low bits, same layout as the four registers side by side
    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic               match_found;
        logic [START_W-1:0] start_position;
    } t_out_word;

    typedef struct packed {
        logic advance;  // a word is accepted this cycle
        logic clear;    // the accepted word closes the stream
    } t_cell_ctrl;

endpackage

@@ rtl/core/fixed_pattern_byte_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Fixed pattern byte matcher
// Compares a byte stream with a configured pattern of up to MAX_LEN bytes and
// reports, for every byte, whether the pattern ends there and where it began.
// ----------------------------------------------------------------------------
// Output: the result word is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the history
// cell row shifts once per byte and the output register is refilled in the cycle it is taken.
// Reset: synchronous; clears configuration, history valid flags, stream
// position and the output register valid. No clearing pass is needed.
module fixed_pattern_byte_matcher_unit #(
    parameter int MAX_LEN       = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fpbm_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fpbm_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpbm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [fpbm_pkg::LEN_W-1:0] MAX_LEN_L = fpbm_pkg::LEN_W'(MAX_LEN);

    logic [fpbm_pkg::LEN_W-1:0]   r_len;
    logic [fpbm_pkg::LEN_W-1:0]   n_len;
    fpbm_pkg::t_pattern           r_pat;
    fpbm_pkg::t_pattern           n_pat;
    logic [POSITION_BITS-1:0]     r_pos;
    logic [POSITION_BITS-1:0]     n_pos;
    logic                         r_out_valid;
    logic                         n_out_valid;
    fpbm_pkg::t_out_word          r_out_word;
    fpbm_pkg::t_out_word          result;

    fpbm_pkg::t_cell_ctrl         ctrl;
    logic                         cfg_write;
    logic                         len_ok;
    logic [fpbm_pkg::LEN_W-1:0]   last_idx;
    logic [POSITION_BITS-1:0]     start_full;

    logic [7:0]                   chain_byte  [MAX_LEN];
    logic                         chain_valid [MAX_LEN];
    logic                         chain_ok    [MAX_LEN];

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    always_comb begin
        n_len = r_len;
        n_pat = r_pat;
        if (cfg_write) begin
            unique case (i_cfg_index)
                fpbm_pkg::CFG_LENGTH:    n_len = i_cfg_data[fpbm_pkg::LEN_W-1:0];
                fpbm_pkg::CFG_PATTERN_0: n_pat[0  +: 8] = i_cfg_data;
                fpbm_pkg::CFG_PATTERN_1: n_pat[8  +: 8] = i_cfg_data;
                fpbm_pkg::CFG_PATTERN_2: n_pat[16 +: 8] = i_cfg_data;
                fpbm_pkg::CFG_PATTERN_3: n_pat[24 +: 8] = i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign o_in_stall   = r_out_valid & i_out_stall;
    assign ctrl.advance = i_in_valid & ~o_in_stall;
    assign ctrl.clear   = i_in_word.end_of_stream;

    // ------------------------------------------------------------------
    // Current byte and history cell row
    // ------------------------------------------------------------------
    assign len_ok   = (r_len != '0) && (r_len <= MAX_LEN_L);
    assign last_idx = r_len - fpbm_pkg::LEN_W'(1);

    assign chain_byte[0]  = i_in_word.data_byte;
    assign chain_valid[0] = 1'b1;
    assign chain_ok[0]    = len_ok
        & (i_in_word.data_byte == r_pat[last_idx[fpbm_pkg::PAT_IDX_W-1:0]]);

    for (genvar k = 1; k < MAX_LEN; k++) begin : g_cell
        fpbm_cell #(
            .K (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_len     (r_len),
            .i_pattern (r_pat),
            .i_byte    (chain_byte[k-1]),
            .i_valid   (chain_valid[k-1]),
            .i_ok      (chain_ok[k-1]),
            .o_byte    (chain_byte[k]),
            .o_valid   (chain_valid[k]),
            .o_ok      (chain_ok[k])
        );
    end

    // ------------------------------------------------------------------
    // Result and stream position
    // ------------------------------------------------------------------
    assign start_full = r_pos - (POSITION_BITS'(r_len) - POSITION_BITS'(1));

    always_comb begin
        result.match_found    = chain_ok[MAX_LEN-1];
        result.start_position = chain_ok[MAX_LEN-1] ?
                                fpbm_pkg::START_W'(start_full) : '0;
    end

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid & i_out_stall;
        if (ctrl.advance) begin
            n_out_valid = 1'b1;
            // restart counting after the last byte of a stream
            n_pos = ctrl.clear ? '0 : r_pos + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pat       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pat       <= n_pat;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_match_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_word.match_found |-> r_out_word.start_position == '0)
        else $error("start position set without a match");

    a_eos_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.advance && ctrl.clear |=> r_pos == '0)
        else $error("stream position not cleared after end of stream");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.advance && !ctrl.clear |=> r_pos == $past(r_pos) + POSITION_BITS'(1))
        else $error("stream position did not advance");

    a_disabled_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.advance && !len_ok |=> r_out_valid && !r_out_word.match_found)
        else $error("match reported with pattern disabled");

endmodule

@@ rtl/core/fpbm_cell.sv @@
// ----------------------------------------------------------------------------
// Fixed pattern byte matcher history cell
// Holds one history byte and its valid flag, shifts them on to the next cell
// and folds its own comparison into the running match flag.
// ----------------------------------------------------------------------------
module fpbm_cell #(
    parameter int K = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fpbm_pkg::t_cell_ctrl               i_ctrl,
    input  logic [fpbm_pkg::LEN_W-1:0]         i_len,
    input  fpbm_pkg::t_pattern                 i_pattern,
    input  logic [7:0]                         i_byte,
    input  logic                               i_valid,
    input  logic                               i_ok,
    output logic [7:0]                         o_byte,
    output logic                               o_valid,
    output logic                               o_ok
);

    localparam logic [fpbm_pkg::LEN_W-1:0] AGE = fpbm_pkg::LEN_W'(K);

    logic [7:0]                   r_byte;
    logic                         r_valid;
    logic                         n_valid;
    logic                         in_use;
    logic [fpbm_pkg::LEN_W-1:0]   pat_idx;
    logic [7:0]                   pat_sel;

    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.advance) begin
            n_valid = i_ctrl.clear ? 1'b0 : i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: only read while valid
    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_byte <= i_byte;
        end
    end

    // this byte lines up with pattern byte len-1-K when K is inside the pattern
    assign in_use  = i_len > AGE;
    assign pat_idx = i_len - AGE - fpbm_pkg::LEN_W'(1);
    assign pat_sel = i_pattern[pat_idx[fpbm_pkg::PAT_IDX_W-1:0]];

    assign o_ok    = i_ok & (!in_use | (r_valid & (r_byte == pat_sel)));
    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

@@ dv/fixed_pattern_byte_matcher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Fixed pattern byte matcher testbench
// Drives byte words into the matcher under random input gaps and output
// stalls. Every accepted byte is run through a local scan of the pattern
// registers and history, and each result word is checked against it. The
// run covers short directed cases and random pattern settings with planted,
// broken and near-miss patterns, one setting streamed with no idling at all.
// ----------------------------------------------------------------------------
module fixed_pattern_byte_matcher_unit_tb;
    import fpbm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_PCT        = 28;
    localparam int DRAIN_CYCLES    = 4;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HIST_DEPTH      = PAT_BYTES - 1;
    localparam int PAT_BITS        = PAT_BYTES * 8;
    localparam int LAST_CFG_INDEX  = (1 << CFG_IDX_W) - 1;
    localparam int RANDOM_PHASES   = 10;
    localparam int BYTES_PER_PHASE = 65;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    fixed_pattern_byte_matcher_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // local copy of the matcher configuration and history
    logic [LEN_W-1:0]    cur_len     = '0;
    logic [PAT_BITS-1:0] cur_pattern = '0;
    logic [7:0]          hist [HIST_DEPTH];
    int                  hist_count  = 0;
    logic [START_W-1:0]  stream_pos  = '0;

    t_in_word  byte_queue [$];
    t_out_word match_queue [$];
    t_out_word want;

    bit quiet         = 1'b0;
    int error_count   = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int settings_seen = 0;
    int quiet_cycles  = 0;

    initial begin
        foreach (hist[k]) hist[k] = '0;
    end

    function automatic t_out_word scan_byte(t_in_word w);
        t_out_word  res;
        int         len;
        int         k;
        logic       hit;
        logic [7:0] seen_byte;
        res = '0;
        len = int'(cur_len);
        hit = 1'b0;
        if (len >= 1 && len <= PAT_BYTES && hist_count + 1 >= len) begin
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
                seen_byte = (k == 0) ? w.data_byte : hist[k-1];
                if (seen_byte != cur_pattern[8*(len-1-k) +: 8]) hit = 1'b0;
            end
        end
        if (hit) begin
            res.match_found    = 1'b1;
            res.start_position = stream_pos - START_W'(len - 1);
        end
        if (w.end_of_stream) begin
            for (k = 0; k < HIST_DEPTH; k++) hist[k] = '0;
            hist_count = 0;
            stream_pos = '0;
        end else begin
            for (k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
            hist[0] = w.data_byte;
            if (hist_count < HIST_DEPTH) hist_count++;
            stream_pos = stream_pos + 1'b1;
        end
        return res;
    endfunction

    // driver: advance to the next byte only when the current word is taken
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            match_queue.push_back(scan_byte(i_in_word));
        end
        if (!(i_in_valid && o_in_stall)) begin
            if (i_rst_n && byte_queue.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_word  <= byte_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (match_queue.size() == 0) begin
                $error("result word with no byte outstanding: match_found %0d start %0d",
                       o_out_word.match_found, o_out_word.start_position);
                error_count++;
            end else begin
                want = match_queue.pop_front();
                if (want.match_found) hits_seen++;
                if (o_out_word.match_found !== want.match_found) begin
                    $error("match_found: expected %0d, got %0d",
                           want.match_found, o_out_word.match_found);
                    error_count++;
                end
                if (o_out_word.start_position !== want.start_position) begin
                    $error("start_position: expected %0d, got %0d",
                           want.start_position, o_out_word.start_position);
                    error_count++;
                end
            end
        end
        i_out_stall <= i_rst_n && !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic void put_byte(logic [7:0] b, logic eos);
        t_in_word w;
        w.data_byte     = b;
        w.end_of_stream = eos;
        byte_queue.push_back(w);
    endfunction

    function automatic logic [PAT_BITS-1:0] random_pattern(bit narrow, logic [7:0] sym_a,
                                                           logic [7:0] sym_b);
        logic [PAT_BITS-1:0] pat;
        int                  k;
        for (k = 0; k < PAT_BYTES; k++) begin
            if (narrow) pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            else        pat[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return pat;
    endfunction

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_LENGTH: cur_len = data[LEN_W-1:0];
            CFG_PATTERN_0, CFG_PATTERN_1, CFG_PATTERN_2, CFG_PATTERN_3:
                cur_pattern[CFG_DATA_W*(int'(idx) - int'(CFG_PATTERN_0)) +: CFG_DATA_W] = data;
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [LEN_W-1:0] len, logic [PAT_BITS-1:0] pat,
                                bit poke_unused);
        logic [CFG_DATA_W-1:0] data;
        int                    n;
        for (n = 0; n < PAT_BITS / CFG_DATA_W; n++) begin
            write_reg(t_cfg_index'(int'(CFG_PATTERN_0) + n), pat[CFG_DATA_W*n +: CFG_DATA_W]);
        end
        if (poke_unused) begin
            for (n = int'(CFG_PATTERN_3) + 1; n <= LAST_CFG_INDEX; n++) begin
                write_reg(n[CFG_IDX_W-1:0], {$urandom, $urandom});
            end
        end
        // stray upper bits of the length word must be ignored
        data = {$urandom, $urandom};
        data[LEN_W-1:0] = len;
        write_reg(CFG_LENGTH, data);
        i_cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    // hold until every byte is taken and every result word has come back
    task automatic settle();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || match_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_stream(int n_items, int len, logic [PAT_BITS-1:0] pat, bit narrow,
                                logic [7:0] sym_a, logic [7:0] sym_b);
        int         added;
        int         pick;
        int         run;
        int         cut;
        int         flip;
        int         k;
        logic [7:0] b;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(0, 99);
            run  = (len >= 1 && len <= PAT_BYTES) ? len : $urandom_range(1, PAT_BYTES);
            if (pick < 50) begin
                // planted pattern, a quarter of them with one byte spoilt
                flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, run - 1) : -1;
                for (k = 0; k < run; k++) begin
                    b = pat[8*k +: 8];
                    if (k == flip) b = b ^ 8'($urandom_range(1, 255));
                    put_byte(b, (k == run - 1) && ($urandom_range(0, 9) == 0));
                end
                added += run;
            end else if (pick < 65) begin
                // prefix cut short by the end of the stream
                cut = $urandom_range(1, run);
                for (k = 0; k < cut; k++) put_byte(pat[8*k +: 8], k == cut - 1);
                added += cut;
            end else begin
                if (narrow) b = $urandom_range(0, 1) ? sym_a : sym_b;
                else        b = 8'($urandom_range(0, 255));
                put_byte(b, $urandom_range(0, 99) < 5);
                added++;
            end
        end
    endtask

    initial begin
        logic [PAT_BITS-1:0] pat;
        logic [7:0]          sym_a;
        logic [7:0]          sym_b;
        bit                  narrow;
        int                  phase_len [RANDOM_PHASES];
        int                  p;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // matching disabled straight out of reset, pattern all zero
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        settle();

        // single byte pattern, across an end of stream
        pat = random_pattern(1'b0, '0, '0);
        pat[7:0] = 8'hFF;
        load_setting(LEN_W'(1), pat, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hFF, 1'b0);
        settle();

        // overlapping hits
        pat = random_pattern(1'b0, '0, '0);
        pat[15:0] = 16'hFFFF;
        load_setting(LEN_W'(2), pat, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        settle();

        // too few bytes since the end of stream, then a clean hit
        pat = random_pattern(1'b0, '0, '0);
        pat[23:0] = 24'h5AFF00;
        load_setting(LEN_W'(3), pat, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h5A, 1'b0);
        settle();

        // lengths above the maximum act as disabled; unused indexes are dropped
        load_setting(LEN_W'(LAST_CFG_INDEX * 9), '0, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        settle();
        load_setting(LEN_W'(PAT_BYTES + 1), random_pattern(1'b0, '0, '0), 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b0);
        settle();

        phase_len = '{1, PAT_BYTES, 5, 0, HIST_DEPTH, 2, (1 << LEN_W) - 1, 17,
                      PAT_BYTES + 1, 9};
        phase_len[7] = $urandom_range(3, PAT_BYTES - 2);
        for (p = 0; p < RANDOM_PHASES; p++) begin
            // in phase 1 the full length pattern is streamed back to back with no stalls
            quiet  = (p == 1);
            narrow = p[0];
            sym_a  = 8'($urandom_range(0, 255));
            sym_b  = 8'($urandom_range(0, 255));
            pat    = random_pattern(narrow, sym_a, sym_b);
            load_setting(LEN_W'(phase_len[p]), pat, 1'b0);
            queue_stream(BYTES_PER_PHASE, phase_len[p], pat, narrow, sym_a, sym_b);
            settle();
        end
        quiet = 1'b0;

        $display("Checked %0d result words, %0d of them hits, over %0d pattern settings",
                 results_seen, hits_seen, settings_seen);
        $display("including end of stream cuts and out of range pattern lengths");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/fpbm_pkg.sv
rtl/core/fpbm_cell.sv
rtl/core/fixed_pattern_byte_matcher_unit.sv
dv/fixed_pattern_byte_matcher_unit_tb.sv
